@@ hdl/sfrc_pkg.sv @@
// Shared types, constants and the CRC byte update for the serial frame receiver.
package sfrc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CRC_W-1:0]   CRC_POLY       = 16'h1021;
  localparam logic [INDEX_W-1:0] FRAME_OVERHEAD = 9'd5;

  localparam logic [BYTE_W-1:0] MASTER_ADDR_RESET = 8'd1;
  localparam logic              CSUM_MODE_RESET   = 1'b0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CSUM_MODE   = 2'd1;

  // Request codes on the input channel.
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic MODE_SIMPLE = 1'b0;
  localparam logic MODE_CRC    = 1'b1;

  typedef enum logic [2:0] {
    ST_PROGRESS   = 3'd0,
    ST_OK         = 3'd1,
    ST_CSUM_ERR   = 3'd2,
    ST_OTHER_ADDR = 3'd3,
    ST_DROPPED    = 3'd4,
    ST_CLEARED    = 3'd5
  } frame_status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] master_address;
    logic              checksum_mode;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_out;
    logic [INDEX_W-1:0] byte_index;
    logic               is_payload;
    logic               frame_end;
    frame_status_e      frame_status;
  } result_t;

  // One byte through the CRC16, MSB first.
  function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/sfrc_intf.sv @@
// Handshake channel interfaces for the frame receiver: input words, results, configuration.
interface sfrc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [sfrc_pkg::BYTE_W-1:0]  byte_in;

  modport source (output valid, output req_type, output byte_in, input ready);
  modport sink (input valid, input req_type, input byte_in, output ready);
endinterface

interface sfrc_out_if;
  logic                         valid;
  logic                         ready;
  logic [sfrc_pkg::BYTE_W-1:0]  byte_out;
  logic [sfrc_pkg::INDEX_W-1:0] byte_index;
  logic                         is_payload;
  logic                         frame_end;
  logic [2:0]                   frame_status;

  modport source (output valid, output byte_out, output byte_index, output is_payload,
                  output frame_end, output frame_status, input ready);
  modport sink (input valid, input byte_out, input byte_index, input is_payload,
                input frame_end, input frame_status, output ready);
endinterface

interface sfrc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfrc_pkg::CFG_IDX_W-1:0]  index;
  logic [sfrc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/sfrc_cfg_regs.sv @@
// Configuration registers: master address and checksum mode.
module sfrc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_valid_i,
  output logic                            wr_ready_o,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [sfrc_pkg::CFG_DATA_W-1:0] wr_data_i,
  output sfrc_pkg::cfg_t                  cfg_o
);

  sfrc_pkg::cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        sfrc_pkg::CFG_MASTER_ADDR: cfg_d.master_address = wr_data_i[sfrc_pkg::BYTE_W-1:0];
        sfrc_pkg::CFG_CSUM_MODE:   cfg_d.checksum_mode  = wr_data_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_address <= sfrc_pkg::MASTER_ADDR_RESET;
      cfg_q.checksum_mode  <= sfrc_pkg::CSUM_MODE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/sfrc_core.sv @@
// Frame state registers and the per-word framing, checksum and status logic.
module sfrc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          req_type_i,
  input  logic [sfrc_pkg::BYTE_W-1:0]   byte_i,
  input  sfrc_pkg::cfg_t                cfg_i,
  output sfrc_pkg::result_t             result_o
);

  localparam int unsigned IW = sfrc_pkg::INDEX_W;
  localparam int unsigned BW = sfrc_pkg::BYTE_W;

  logic [IW-1:0]              pos_q, pos_d;
  logic [IW-1:0]              len_q, len_d;
  logic [BW-1:0]              sum_q, sum_d;
  logic [sfrc_pkg::CRC_W-1:0] crc_q, crc_d;
  logic [BW-1:0]              src_q, src_d;
  logic [BW-1:0]              dst_q, dst_d;
  logic                       hold_q, hold_d;

  logic [IW:0]   idx_inc;
  logic [IW-1:0] len_eff;
  logic [BW-1:0] src_eff, dst_eff;
  logic          last_byte, good;

  always_comb begin
    idx_inc   = {1'b0, pos_q} + 10'd1;
    len_eff   = (pos_q == 9'd1) ? len_q + {1'b0, byte_i} : len_q;
    dst_eff   = (pos_q == 9'd0) ? byte_i : dst_q;
    src_eff   = (pos_q == 9'd2) ? byte_i : src_q;
    last_byte = idx_inc >= {1'b0, len_eff};
    if (cfg_i.checksum_mode == sfrc_pkg::MODE_CRC) begin
      good = ({byte_i, src_eff} == crc_q);
    end else begin
      good = (byte_i == BW'(9'h100 - {1'b0, sum_q}));
    end
  end

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    sum_d  = sum_q;
    crc_d  = crc_q;
    src_d  = src_q;
    dst_d  = dst_q;
    hold_d = hold_q;

    result_o.byte_out     = byte_i;
    result_o.byte_index   = pos_q;
    result_o.is_payload   = 1'b0;
    result_o.frame_end    = 1'b0;
    result_o.frame_status = sfrc_pkg::ST_PROGRESS;

    if (req_type_i == sfrc_pkg::REQ_CLEAR) begin
      pos_d  = '0;
      len_d  = sfrc_pkg::FRAME_OVERHEAD;
      sum_d  = '0;
      crc_d  = '0;
      src_d  = '0;
      dst_d  = '0;
      hold_d = 1'b0;
      result_o.byte_out     = '0;
      result_o.byte_index   = '0;
      result_o.frame_status = sfrc_pkg::ST_CLEARED;
    end else if (hold_q) begin
      result_o.frame_status = sfrc_pkg::ST_DROPPED;
    end else begin
      len_d = len_eff;
      src_d = src_eff;
      dst_d = dst_eff;
      result_o.is_payload = (pos_q >= 9'd4) && !last_byte;
      if (last_byte) begin
        result_o.frame_end = 1'b1;
        if (!good) begin
          result_o.frame_status = sfrc_pkg::ST_CSUM_ERR;
          hold_d = 1'b1;
          pos_d  = idx_inc[IW-1:0];
        end else if (dst_eff == cfg_i.master_address) begin
          result_o.frame_status = sfrc_pkg::ST_OK;
          hold_d = 1'b1;
          pos_d  = idx_inc[IW-1:0];
        end else begin
          // Good frame for another node: re-arm right away.
          result_o.frame_status = sfrc_pkg::ST_OTHER_ADDR;
          pos_d  = '0;
          len_d  = sfrc_pkg::FRAME_OVERHEAD;
          sum_d  = '0;
          crc_d  = '0;
          src_d  = '0;
          dst_d  = '0;
          hold_d = 1'b0;
        end
      end else begin
        sum_d = sum_q + byte_i;
        // The source byte slot carries the CRC low byte, so it stays out of the CRC.
        if (pos_q != 9'd2) begin
          crc_d = sfrc_pkg::crc16_feed(crc_q, byte_i);
        end
        pos_d = idx_inc[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= sfrc_pkg::FRAME_OVERHEAD;
      sum_q  <= '0;
      crc_q  <= '0;
      src_q  <= '0;
      dst_q  <= '0;
      hold_q <= 1'b0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      sum_q  <= sum_d;
      crc_q  <= crc_d;
      src_q  <= src_d;
      dst_q  <= dst_d;
      hold_q <= hold_d;
    end
  end

endmodule

@@ hdl/sfrc_out_buf.sv @@
// Result register with a skid stage so new words are taken while a result waits.
module sfrc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfrc_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sfrc_pkg::result_t out_data_o
);

  logic              out_v_q, out_v_d;
  logic              skid_v_q, skid_v_d;
  sfrc_pkg::result_t out_q, out_d;
  sfrc_pkg::result_t skid_q, skid_d;
  logic              in_fire;

  assign in_ready_o = !skid_v_q;
  assign in_fire    = in_valid_i && !skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = in_data_i;
        out_v_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d   = in_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/serial_frame_receiver_checksum.sv @@
// A result word is registered from its input word when that word is accepted.
// Throughput: one word per cycle unless the skid stage holds a word; the framing state and the byte-wide CRC16
// update are combinational between input acceptance and the result register.
// A stalled result keeps accepting one more word into the skid stage.
// Reset (async, active low) clears the frame state, empties the result stages and
// loads master address 1 and the simple checksum mode.
module serial_frame_receiver_checksum (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfrc_in_if.sink    rx_i,
  sfrc_out_if.source res_o,
  sfrc_cfg_if.sink   cfg_i
);

  sfrc_pkg::cfg_t    cfg;
  sfrc_pkg::result_t core_res;
  sfrc_pkg::result_t buf_res;
  logic              accept;

  assign accept = rx_i.valid && rx_i.ready;

  sfrc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  sfrc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (rx_i.req_type),
    .byte_i     (rx_i.byte_in),
    .cfg_i      (cfg),
    .result_o   (core_res)
  );

  sfrc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_i.ready),
    .in_data_i   (core_res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (buf_res)
  );

  assign res_o.byte_out     = buf_res.byte_out;
  assign res_o.byte_index   = buf_res.byte_index;
  assign res_o.is_payload   = buf_res.is_payload;
  assign res_o.frame_end    = buf_res.frame_end;
  assign res_o.frame_status = buf_res.frame_status;

endmodule

@@ hdl/sfrc_checker.sv @@
// Port-level checks for the frame receiver, bound to the top level.
module sfrc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sfrc_pkg::BYTE_W-1:0]  byte_out_i,
  input logic [sfrc_pkg::INDEX_W-1:0] byte_index_i,
  input logic                         is_payload_i,
  input logic                         frame_end_i,
  input logic [2:0]                   frame_status_i
);

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_out_i)
      && $stable(byte_index_i) && $stable(frame_status_i))
    else $error("stalled result word changed");

  // Input back-pressure only follows a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input not ready without a stalled result");

  // Only the check byte finishes a frame, and it always carries a verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |->
      frame_status_i == sfrc_pkg::ST_OK || frame_status_i == sfrc_pkg::ST_CSUM_ERR
      || frame_status_i == sfrc_pkg::ST_OTHER_ADDR)
    else $error("frame end without a frame verdict");

  // A payload word sits past the header and is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_payload_i |->
      byte_index_i >= 9'd4 && frame_status_i == sfrc_pkg::ST_PROGRESS)
    else $error("payload flag on a non-payload position");

  // A clear reports an empty word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_status_i == sfrc_pkg::ST_CLEARED |->
      byte_out_i == '0 && byte_index_i == '0 && !is_payload_i && !frame_end_i)
    else $error("clear result carries data");

endmodule

bind serial_frame_receiver_checksum sfrc_checker u_sfrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (rx_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .byte_out_i     (res_o.byte_out),
  .byte_index_i   (res_o.byte_index),
  .is_payload_i   (res_o.is_payload),
  .frame_end_i    (res_o.frame_end),
  .frame_status_i (res_o.frame_status)
);

@@ bench/sfrc_frame_checker.sv @@
// Passive checker for the frame receiver: tracks configuration, predicts each result word and compares.
`timescale 1ns / 100ps

module sfrc_frame_checker
  import sfrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sfrc_in_if          rx_i,
  sfrc_out_if         res_i,
  sfrc_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  cfg_t               cfg_q;
  logic [INDEX_W-1:0] pos_q;
  logic [INDEX_W-1:0] len_q;
  logic [BYTE_W-1:0]  sum_q;
  logic [CRC_W-1:0]   crc_q;
  logic [BYTE_W-1:0]  src_q;
  logic [BYTE_W-1:0]  dst_q;
  logic               held_q;
  result_t            expected_results[$];

  // Bit-serial form of the CCITT update: feedback is the top CRC bit xor the next data bit.
  function automatic logic [CRC_W-1:0] crc_shift_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ d[i];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  function automatic void rearm_frame();
    pos_q  = '0;
    len_q  = FRAME_OVERHEAD;
    sum_q  = '0;
    crc_q  = '0;
    src_q  = '0;
    dst_q  = '0;
    held_q = 1'b0;
  endfunction

  function automatic result_t predict_frame_word(input logic req, input logic [BYTE_W-1:0] b);
    result_t     r;
    logic        good;
    int unsigned idx;
    r.byte_out     = b;
    r.byte_index   = pos_q;
    r.is_payload   = 1'b0;
    r.frame_end    = 1'b0;
    r.frame_status = ST_PROGRESS;
    if (req == REQ_CLEAR) begin
      rearm_frame();
      r.byte_out     = '0;
      r.byte_index   = '0;
      r.frame_status = ST_CLEARED;
      return r;
    end
    if (held_q) begin
      r.frame_status = ST_DROPPED;
      return r;
    end
    idx = pos_q;
    if (idx == 0) dst_q = b;
    if (idx == 1) len_q = len_q + b;
    if (idx == 2) src_q = b;
    if (idx >= 4 && idx + 1 < len_q) r.is_payload = 1'b1;
    if (idx + 1 >= len_q) begin
      r.frame_end = 1'b1;
      if (cfg_q.checksum_mode == MODE_SIMPLE) begin
        good = (BYTE_W'(b + sum_q) == '0);
      end else begin
        good = ({b, src_q} == crc_q);
      end
      if (!good || dst_q == cfg_q.master_address) begin
        r.frame_status = good ? ST_OK : ST_CSUM_ERR;
        held_q = 1'b1;
        pos_q  = pos_q + 1'b1;
      end else begin
        r.frame_status = ST_OTHER_ADDR;
        rearm_frame();
      end
    end else begin
      sum_q = sum_q + b;
      // The source byte is left out of the CRC because it carries the low CRC byte.
      if (idx != 2) crc_q = crc_shift_byte(crc_q, b);
      pos_q = pos_q + 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      cfg_q.master_address = MASTER_ADDR_RESET;
      cfg_q.checksum_mode  = CSUM_MODE_RESET;
      rearm_frame();
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      // Results are compared before this edge's input word is predicted.
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: byte_out %0d, byte_index %0d, status %0d",
                 res_i.byte_out, res_i.byte_index, res_i.frame_status);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("byte_out", want.byte_out, res_i.byte_out);
          check_field("byte_index", want.byte_index, res_i.byte_index);
          check_field("is_payload", want.is_payload, res_i.is_payload);
          check_field("frame_end", want.frame_end, res_i.frame_end);
          check_field("frame_status", want.frame_status, res_i.frame_status);
        end
      end
      if (rx_i.valid && rx_i.ready) begin
        expected_results.push_back(predict_frame_word(rx_i.req_type, rx_i.byte_in));
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_MASTER_ADDR: cfg_q.master_address = cfg_i.data;
          CFG_CSUM_MODE:   cfg_q.checksum_mode  = cfg_i.data[0];
          default: ;
        endcase
      end
    end
    pending_o = expected_results.size();
  end

endmodule

@@ bench/tb_serial_frame_receiver_checksum.sv @@
// Top of the frame receiver testbench: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 100ps

module tb_serial_frame_receiver_checksum;
  import sfrc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned IDLE_PERCENT   = 35;
  localparam int unsigned PHASE_WORDS    = 85;
  localparam int unsigned END_CYCLES     = 8;
  // Unused register indexes; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n;
  bit                no_idle = 1'b0;
  logic [BYTE_W-1:0] cur_addr = MASTER_ADDR_RESET;
  logic              cur_mode = CSUM_MODE_RESET;
  logic [BYTE_W-1:0] frame_q[$];
  int unsigned       words_sent = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       fail_count;
  int unsigned       pending;

  sfrc_in_if  rx_if();
  sfrc_out_if res_if();
  sfrc_cfg_if cfg_if();

  serial_frame_receiver_checksum DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  sfrc_frame_checker u_frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_i         (rx_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    res_if.ready = 1'b0;
    forever @(negedge clk) res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("serial_frame_receiver_checksum test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic req, input logic [BYTE_W-1:0] b);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid    <= 1'b1;
    rx_if.req_type <= req;
    rx_if.byte_in  <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_bytes(input int unsigned first, input int unsigned last);
    for (int unsigned i = first; i < last; i++) send_word(REQ_BYTE, frame_q[i]);
  endtask

  // Stops the sender until every result word in flight has come back.
  task automatic drain();
    rx_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Leaves valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    if (idx == CFG_MASTER_ADDR) cur_addr = data;
    else if (idx == CFG_CSUM_MODE) cur_mode = data[0];
  endtask

  task automatic configure(input logic [BYTE_W-1:0] addr, input logic [CFG_DATA_W-1:0] mode);
    write_reg(CFG_MASTER_ADDR, addr);
    write_reg(CFG_CSUM_MODE, mode);
    cfg_if.valid <= 1'b0;
  endtask

  // Builds a whole frame into frame_q with the check bytes for the given mode.
  function automatic void build_frame(input logic [BYTE_W-1:0] dst, input int unsigned plen,
                                      input logic crc_form, input bit corrupt);
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] sum;
    int unsigned       k;
    frame_q.delete();
    frame_q.push_back(dst);
    frame_q.push_back(BYTE_W'(plen));
    frame_q.push_back(BYTE_W'($urandom_range(255)));
    frame_q.push_back(BYTE_W'($urandom_range(255)));
    repeat (plen) frame_q.push_back(BYTE_W'($urandom_range(255)));
    if (crc_form == MODE_CRC) begin
      crc = '0;
      foreach (frame_q[i]) if (i != 2) crc = crc16_feed(crc, frame_q[i]);
      frame_q[2] = crc[7:0];
      frame_q.push_back(crc[15:8]);
    end else begin
      sum = '0;
      foreach (frame_q[i]) sum = sum + frame_q[i];
      frame_q.push_back(BYTE_W'(-sum));
    end
    // Never touch the length byte, so the frame keeps its size.
    if (corrupt) begin
      k = $urandom_range(frame_q.size() - 1, 2);
      frame_q[k] = frame_q[k] ^ BYTE_W'(1 << $urandom_range(BYTE_W - 1));
    end
  endfunction

  task automatic random_phase(input int unsigned words, input bit with_long);
    int unsigned       start;
    int unsigned       kind;
    int unsigned       plen;
    logic [BYTE_W-1:0] dst;
    bit                bad;
    start = words_sent;
    if (with_long) begin
      build_frame(cur_addr, 255, cur_mode, 1'b0);
      send_bytes(0, frame_q.size());
      send_word(REQ_BYTE, BYTE_W'($urandom_range(255)));
      send_word(REQ_CLEAR, BYTE_W'($urandom_range(255)));
    end
    while (words_sent - start < words) begin
      kind = $urandom_range(99);
      plen = $urandom_range(12);
      dst  = ($urandom_range(99) < 60) ? cur_addr : BYTE_W'($urandom_range(255));
      bad  = ($urandom_range(99) < 20);
      build_frame(dst, plen, cur_mode, bad);
      if (kind < 70) begin
        send_bytes(0, frame_q.size());
        if (bad || dst == cur_addr) begin
          repeat ($urandom_range(2)) send_word(REQ_BYTE, BYTE_W'($urandom_range(255)));
          send_word(REQ_CLEAR, BYTE_W'($urandom_range(255)));
        end
      end else if (kind < 85) begin
        // Frame cut short by a clear.
        send_bytes(0, $urandom_range(frame_q.size() - 1, 1));
        send_word(REQ_CLEAR, BYTE_W'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(8, 1)) send_word(REQ_BYTE, BYTE_W'($urandom_range(255)));
        send_word(REQ_CLEAR, BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.req_type = REQ_BYTE;
    rx_if.byte_in  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_MASTER_ADDR;
    cfg_if.data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Spare indexes alias the real registers if the decode ignores the upper index bit.
    write_reg(CFG_SPARE_A, 8'h00);
    write_reg(CFG_SPARE_B, 8'hFF);
    cfg_if.valid <= 1'b0;

    build_frame(MASTER_ADDR_RESET, 1, MODE_SIMPLE, 1'b0);
    send_bytes(0, frame_q.size());
    send_word(REQ_BYTE, 8'h00);
    send_word(REQ_CLEAR, 8'hFF);
    build_frame(8'hFF, 0, MODE_SIMPLE, 1'b0);
    send_bytes(0, frame_q.size());
    build_frame(MASTER_ADDR_RESET, 1, MODE_SIMPLE, 1'b1);
    send_bytes(0, frame_q.size());
    send_word(REQ_CLEAR, 8'h00);
    // CRC frame that starts under the simple mode; the mode at the check byte decides.
    build_frame(MASTER_ADDR_RESET, 1, MODE_CRC, 1'b0);
    send_bytes(0, 3);
    drain();
    write_reg(CFG_CSUM_MODE, 8'h01);
    cfg_if.valid <= 1'b0;
    send_bytes(3, frame_q.size());
    send_word(REQ_CLEAR, 8'h00);

    drain();
    configure(8'h00, 8'hFF);
    random_phase(PHASE_WORDS, 1'b1);
    drain();
    configure(8'hFF, 8'hFE);
    random_phase(PHASE_WORDS, 1'b0);
    drain();
    configure(8'hFF, 8'h01);
    no_idle = 1'b1;
    random_phase(PHASE_WORDS, 1'b0);
    drain();
    no_idle = 1'b0;
    configure(BYTE_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(255)) & 8'hFE);
    random_phase(PHASE_WORDS, 1'b0);
    drain();
    configure(BYTE_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(255)) | 8'h01);
    random_phase(PHASE_WORDS, 1'b0);

    drain();
    repeat (END_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("serial_frame_receiver_checksum test passed");
    end else begin
      $display("serial_frame_receiver_checksum test failed");
    end
    $finish;
  end

endmodule
